@@ rtl/chte_pkg.sv @@
// ----------------------------------------------------------------------------
// chte_pkg: shared types and codes for the chained hash table engine
// Command, status and controller state codes, plus the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package chte_pkg;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_DESTROY = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_REQ,
    S_CMP,
    S_CREATE,
    S_FREEPOP,
    S_DESTROY,
    S_CLEAR,
    S_OUT
  } state_t;

  localparam logic [31:0] HASH_MUL_HI = 32'd53377;
  localparam logic [31:0] HASH_MUL_LO = 32'd248735;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic hash;       // compute bucket
    logic head_rd;    // read bucket head into cur
    logic ent_rd;     // issue key/link read at cur
    logic step;       // advance cur along chain
    logic create;     // perform create write-back
    logic pop_rd;     // read top of free stack
    logic destroy;    // perform destroy write-back
    logic clr_start;  // begin clear sweep
    logic clr_step;   // advance the clear sweep by one entry
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_ok;     // cur points at a chain entry
    logic key_eq;     // key read at cur matches
    logic pool_empty; // free count is zero
    logic clr_done;   // last sweep entry written
    logic walk_max;   // walk bound reached
  } sts_t;

endpackage

@@ rtl/chte_ctrl.sv @@
// ----------------------------------------------------------------------------
// chte_ctrl: command sequencer
// Steps each item through hash and then a chain walk and write-back or a clear
// sweep; holds the result.
module chte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  chte_pkg::cmd_t  cmd,
  input  logic            out_fire,
  input  chte_pkg::sts_t  sts,
  output chte_pkg::ctl_t  ctl,
  output logic            busy,
  output logic            out_valid,
  output logic            hit,
  output logic            full
);

  chte_pkg::state_t state, state_next;
  logic hit_next, full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chte_pkg::S_IDLE;
      hit   <= 1'b0;
      full  <= 1'b0;
    end else begin
      state <= state_next;
      hit   <= hit_next;
      full  <= full_next;
    end
  end

  always_comb begin
    state_next = state;
    hit_next   = hit;
    full_next  = full;
    ctl        = '0;
    case (state)
      chte_pkg::S_IDLE: begin
        if (in_fire) begin
          ctl.load   = 1'b1;
          hit_next   = 1'b0;
          full_next  = 1'b0;
          state_next = chte_pkg::S_HASH;
        end
      end
      chte_pkg::S_HASH: begin
        ctl.hash = 1'b1;
        if (cmd == chte_pkg::CMD_CLEAR) begin
          ctl.clr_start = 1'b1;
          state_next    = chte_pkg::S_CLEAR;
        end else begin
          state_next = chte_pkg::S_HEAD;
        end
      end
      chte_pkg::S_HEAD: begin
        ctl.head_rd = 1'b1;
        state_next  = chte_pkg::S_REQ;
      end
      chte_pkg::S_REQ: begin
        if (sts.cur_ok && !sts.walk_max) begin
          ctl.ent_rd = 1'b1;
          state_next = chte_pkg::S_CMP;
        end else if (cmd == chte_pkg::CMD_CREATE) begin
          if (sts.pool_empty) begin
            full_next  = 1'b1;
            state_next = chte_pkg::S_OUT;
          end else begin
            ctl.pop_rd = 1'b1;
            state_next = chte_pkg::S_FREEPOP;
          end
        end else begin
          state_next = chte_pkg::S_OUT;
        end
      end
      chte_pkg::S_CMP: begin
        if (sts.key_eq) begin
          hit_next   = 1'b1;
          state_next = (cmd == chte_pkg::CMD_DESTROY) ? chte_pkg::S_DESTROY
                                                      : chte_pkg::S_OUT;
        end else begin
          ctl.step   = 1'b1;
          state_next = chte_pkg::S_REQ;
        end
      end
      chte_pkg::S_FREEPOP: state_next = chte_pkg::S_CREATE;
      chte_pkg::S_CREATE: begin
        ctl.create = 1'b1;
        state_next = chte_pkg::S_OUT;
      end
      chte_pkg::S_DESTROY: begin
        ctl.destroy = 1'b1;
        state_next  = chte_pkg::S_OUT;
      end
      chte_pkg::S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) state_next = chte_pkg::S_OUT;
      end
      chte_pkg::S_OUT: begin
        if (out_fire) state_next = chte_pkg::S_IDLE;
      end
      default: state_next = chte_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state != chte_pkg::S_IDLE);
  assign out_valid = (state == chte_pkg::S_OUT);

`ifndef ASSERT_OFF
  a_hit_full: assert property (@(posedge clk) disable iff (rst) !(hit && full))
    else $error("hit and full both set");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> state == chte_pkg::S_HASH)
    else $error("load did not start hash");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_fire) |=> out_valid)
    else $error("result dropped while stalled");
`endif

endmodule

@@ rtl/chte_dpath.sv @@
// ----------------------------------------------------------------------------
// chte_dpath: hash, chain memories and free stack
// Key and link memories, bucket heads with valid bits, free stack with clear
// sweep, and the per-item walk registers.
// ----------------------------------------------------------------------------
module chte_dpath #(
  parameter int NUM_BUCKETS  = 32,
  parameter int POOL_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  chte_pkg::ctl_t       ctl,
  input  logic [1:0]           in_cmd,
  input  logic [63:0]          in_key,
  input  logic                 hit,
  output chte_pkg::cmd_t       cmd,
  output chte_pkg::sts_t       sts,
  output logic [7:0]           res_handle
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = PW + 1;

  logic [63:0]   key;
  logic [BW-1:0] bucket;
  logic [PW:0]   head_mem [NUM_BUCKETS];   // valid bit on top
  logic [NUM_BUCKETS-1:0] head_v;
  logic [63:0]   key_mem  [POOL_ENTRIES];
  logic [PW:0]   link_mem [POOL_ENTRIES];
  logic [PW-1:0] free_mem [POOL_ENTRIES];
  logic [63:0]   rd_key;
  logic [PW:0]   rd_link;
  logic [PW:0]   at_link;
  logic [PW-1:0] cur, prev, pop_idx;
  logic          cur_ok, prev_ok;
  logic [CW-1:0] free_count, steps;
  logic [PW-1:0] clr_idx;
  logic          clr_run;
  logic [31:0]   mix;
  logic          pop_vld;
  logic          lnk_we, fr_we;
  logic [PW-1:0] lnk_addr, fr_addr, fr_data;
  logic [PW:0]   lnk_data;

  assign mix = 32'(key[63:32] * chte_pkg::HASH_MUL_HI)
             + 32'(key[31:0] * chte_pkg::HASH_MUL_LO);

  // one write port per memory: new entry init, predecessor relink, sweep/push
  always_comb begin
    lnk_we   = 1'b0;
    lnk_addr = prev;
    lnk_data = at_link;
    if (pop_vld) begin
      lnk_we   = 1'b1;
      lnk_addr = pop_idx;
      lnk_data = '0;
    end else if ((ctl.create || ctl.destroy) && prev_ok) begin
      lnk_we   = 1'b1;
      lnk_data = ctl.create ? {1'b1, pop_idx} : at_link;
    end
  end

  always_comb begin
    fr_we   = 1'b0;
    fr_addr = PW'(free_count);
    fr_data = cur;
    if (clr_run || ctl.clr_step) begin
      fr_we   = 1'b1;
      fr_addr = clr_idx;
      fr_data = clr_idx;
    end else if (ctl.destroy && free_count < CW'(POOL_ENTRIES)) begin
      fr_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= in_key;
      cmd <= chte_pkg::cmd_t'(in_cmd);
    end
    if (ctl.hash) bucket <= mix[BW-1:0];
    if (ctl.ent_rd) begin
      rd_key  <= key_mem[cur];
      rd_link <= link_mem[cur];
    end
    if (ctl.pop_rd) pop_idx <= free_mem[PW'(free_count - CW'(1))];
    if (pop_vld) key_mem[pop_idx] <= key;
    if (lnk_we) link_mem[lnk_addr] <= lnk_data;
    if (fr_we) free_mem[fr_addr] <= fr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v     <= '0;
      free_count <= CW'(POOL_ENTRIES);
      clr_run    <= 1'b1;
      clr_idx    <= '0;
      cur_ok     <= 1'b0;
      prev_ok    <= 1'b0;
      steps      <= '0;
      pop_vld    <= 1'b0;
    end else begin
      pop_vld <= ctl.pop_rd;
      if (clr_run || ctl.clr_step) begin
        clr_idx <= clr_idx + PW'(1);
        if (clr_idx == PW'(POOL_ENTRIES - 1)) clr_run <= 1'b0;
      end
      if (ctl.clr_start) begin
        head_v     <= '0;
        free_count <= CW'(POOL_ENTRIES);
        clr_idx    <= '0;
      end
      if (ctl.head_rd) begin
        cur_ok  <= head_v[bucket];
        cur     <= head_mem[bucket][PW-1:0];
        prev_ok <= 1'b0;
        prev    <= '0;
        steps   <= '0;
      end
      if (ctl.step) begin
        prev    <= cur;
        prev_ok <= 1'b1;
        cur_ok  <= rd_link[PW];
        cur     <= rd_link[PW-1:0];
        steps   <= steps + CW'(1);
      end
      if (ctl.create) begin
        free_count <= free_count - CW'(1);
        cur        <= pop_idx;
        if (!prev_ok) begin
          head_v[bucket]   <= 1'b1;
          head_mem[bucket] <= {1'b1, pop_idx};
        end
      end
      if (ctl.destroy) begin
        if (!prev_ok) begin
          head_v[bucket]   <= at_link[PW];
          head_mem[bucket] <= at_link;
        end
        if (free_count < CW'(POOL_ENTRIES)) free_count <= free_count + CW'(1);
      end
    end
  end

  assign at_link = rd_link;

  assign sts.cur_ok     = cur_ok;
  assign sts.key_eq     = (rd_key == key);
  assign sts.pool_empty = (free_count == '0);
  assign sts.clr_done   = (clr_idx == PW'(POOL_ENTRIES - 1));
  assign sts.walk_max   = (steps == CW'(POOL_ENTRIES));

  always_comb begin
    res_handle = '0;
    if (cmd == chte_pkg::CMD_CREATE && ctl == '0 && !hit) res_handle = 8'(cur);
    if (hit && cmd != chte_pkg::CMD_CREATE) res_handle = 8'(cur);
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(POOL_ENTRIES))
    else $error("free count overflow");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    ctl.create |-> free_count != '0)
    else $error("create on empty pool");
  a_step: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> prev_ok)
    else $error("walk lost predecessor");
`endif

endmodule

@@ rtl/chained_hash_table_engine.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_engine: separate-chaining hash table
// Top level joining the command sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: tdata[1:0] command, tdata[65:2] key.
//   m_axis returns one result item per command: tdata[1:0] status,
//   tdata[9:2] handle.
//   One item is processed at a time. A command walks its bucket's chain
//   with one memory read and compare per entry, up to the first match; a
//   create that allocates then pops the free stack and writes the entry,
//   and clear sweeps the free stack.
//   After reset the free stack is rebuilt by a sweep over all POOL_ENTRIES
//   entries; s_axis_tready stays low until it ends.
//   A stalled m_axis holds its result; no new item is taken until it goes.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int NUM_BUCKETS  = 32,
  parameter int POOL_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // command[1:0], key[65:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], handle[9:2], zero fill
);

  chte_pkg::ctl_t ctl;
  chte_pkg::sts_t sts;
  chte_pkg::cmd_t cmd;
  logic busy, hit, full, in_fire, out_fire, sweep;
  logic [7:0] handle;
  logic [1:0] status;

  // hold off commands during the power-up free stack sweep
  always_ff @(posedge clk) begin
    if (rst) sweep <= 1'b1;
    else if (sts.clr_done) sweep <= 1'b0;
  end

  assign s_axis_tready = !busy && !sweep;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  chte_ctrl u_ctrl (
    .clk, .rst, .in_fire, .cmd, .out_fire, .sts, .ctl, .busy,
    .out_valid(m_axis_tvalid), .hit, .full
  );

  chte_dpath #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_dpath (
    .clk, .rst, .ctl, .in_cmd(s_axis_tdata[1:0]), .in_key(s_axis_tdata[65:2]),
    .hit, .cmd, .sts, .res_handle(handle)
  );

  always_comb begin
    status = chte_pkg::ST_OK;
    if (full) status = chte_pkg::ST_FULL;
    else if (cmd == chte_pkg::CMD_CREATE) status = hit ? chte_pkg::ST_MISS
                                                        : chte_pkg::ST_OK;
    else if (cmd != chte_pkg::CMD_CLEAR && !hit) status = chte_pkg::ST_MISS;
  end

  assign m_axis_tdata = {6'd0, (status == chte_pkg::ST_OK) ? handle : 8'd0, status};

endmodule

@@ tb/chained_hash_table_engine_tb.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_engine_tb: self-checking bench for the hash table engine
// Drives create/find/destroy/clear commands over the input stream, predicts
// each result with a behavioral hash table and compares it on the output.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_tb;

  localparam int NB = 32;
  localparam int NE = 256;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int NUM_RANDOM = 620;

  typedef struct packed {
    chte_pkg::status_t status;
    logic [7:0]        handle;
  } table_result_t;

  typedef struct {
    chte_pkg::cmd_t    command;
    logic [63:0]       key;
    logic              typed;     // expected result given in the row
    chte_pkg::status_t status;
    logic [7:0]        handle;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // command[1:0], key[65:2], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // status[1:0], handle[9:2], zero fill

  chained_hash_table_engine #(.NUM_BUCKETS(NB), .POOL_ENTRIES(NE)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow table: chains as linked entries, free stack of handles.
  logic        shd_head_ok [NB];
  logic [7:0]  shd_head    [NB];
  logic [63:0] shd_key     [NE];
  logic        shd_link_ok [NE];
  logic [7:0]  shd_link    [NE];
  logic [7:0]  shd_free    [NE];
  int          shd_free_n;
  logic [63:0] live_keys[$];    // keys currently in the table

  table_result_t pending_results[$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  bit  hold_sink = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic [4:0] key_bucket(logic [63:0] k);
    logic [63:0] mix;
    mix = 64'd53377 * (k >> 32) + 64'd248735 * k;
    return mix[4:0];
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < NB; i++) begin
      shd_head_ok[i] = 1'b0;
      shd_head[i] = '0;
    end
    for (int i = 0; i < NE; i++) begin
      shd_free[i] = i[7:0];
      shd_link_ok[i] = 1'b0;
      shd_link[i] = '0;
    end
    shd_free_n = NE;
    live_keys.delete();
  endfunction

  function automatic table_result_t table_apply(chte_pkg::cmd_t c, logic [63:0] k);
    table_result_t r;
    logic [4:0] b;
    logic ok, hit, prev_ok;
    logic [7:0] cur, prev, at, n;
    int steps;
    r.status = chte_pkg::ST_OK;
    r.handle = '0;
    if (c == chte_pkg::CMD_CLEAR) begin
      table_clear();
      return r;
    end
    b = key_bucket(k);
    ok = shd_head_ok[b];
    cur = shd_head[b];
    hit = 1'b0; prev_ok = 1'b0; prev = '0; at = '0; steps = 0;
    while (ok && !hit && steps < NE) begin
      if (shd_key[cur] == k) begin
        hit = 1'b1;
        at = cur;
      end else begin
        prev = cur;
        prev_ok = 1'b1;
        ok = shd_link_ok[cur];
        cur = shd_link[cur];
        steps++;
      end
    end
    case (c)
      chte_pkg::CMD_CREATE: begin
        if (hit) r.status = chte_pkg::ST_MISS;
        else if (shd_free_n == 0) r.status = chte_pkg::ST_FULL;
        else begin
          shd_free_n--;
          n = shd_free[shd_free_n];
          shd_key[n] = k;
          shd_link_ok[n] = 1'b0;
          shd_link[n] = '0;
          if (prev_ok) begin
            shd_link_ok[prev] = 1'b1;
            shd_link[prev] = n;
          end else begin
            shd_head_ok[b] = 1'b1;
            shd_head[b] = n;
          end
          r.handle = n;
          live_keys.push_back(k);
        end
      end
      chte_pkg::CMD_FIND: begin
        if (hit) r.handle = at;
        else r.status = chte_pkg::ST_MISS;
      end
      default: begin
        if (!hit) r.status = chte_pkg::ST_MISS;
        else begin
          if (prev_ok) begin
            shd_link_ok[prev] = shd_link_ok[at];
            shd_link[prev] = shd_link[at];
          end else begin
            shd_head_ok[b] = shd_link_ok[at];
            shd_head[b] = shd_link[at];
          end
          shd_link_ok[at] = 1'b0;
          shd_link[at] = '0;
          if (shd_free_n < NE) begin
            shd_free[shd_free_n] = at;
            shd_free_n++;
          end
          r.handle = at;
          foreach (live_keys[i])
            if (live_keys[i] == k) begin
              live_keys.delete(i);
              break;
            end
        end
      end
    endcase
    return r;
  endfunction

  // Send one command; wait for its acceptance, then record the prediction.
  task automatic send_command(chte_pkg::cmd_t c, logic [63:0] k, bit typed = 0,
                              chte_pkg::status_t ts = chte_pkg::ST_OK,
                              logic [7:0] th = '0);
    table_result_t r;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, k, c};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = table_apply(c, k);
    if (typed && (r.status != ts || r.handle != th)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("row check: cmd %0d key %h table says %0d/%0d, row says %0d/%0d",
                 c, k, r.status, r.handle, ts, th);
    end
    pending_results.push_back(r);
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        table_result_t want;
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] != want.status || m_axis_tdata[9:2] != want.handle
            || m_axis_tdata[15:10] != '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d handle %0d, got %0d handle %0d",
                     want.status, want.handle, m_axis_tdata[1:0], m_axis_tdata[9:2]);
        end
      end
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired");
      $display("** chained_hash_table_engine: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Keys that collide in bucket 0 build long chains.
  function automatic logic [63:0] bucket0_key();
    logic [63:0] k;
    do k = {$urandom_range(0, 3), $urandom_range(0, 255)};
    while (key_bucket(k) != 0);
    return k;
  endfunction

  initial begin
    stim_row_t rows[$];
    logic [63:0] ka, kb, kc, k;
    int roll, r2;
    table_clear();
    for (int i = 0; i < NE; i++) shd_key[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    ka = bucket0_key();
    do kb = bucket0_key(); while (kb == ka);
    do kc = bucket0_key(); while (kc == ka || kc == kb);
    // Directed table: extremes, every command, each special case.
    rows.push_back('{chte_pkg::CMD_FIND,    64'd0, 1'b1, chte_pkg::ST_MISS, 8'd0});
    rows.push_back('{chte_pkg::CMD_DESTROY, 64'd0, 1'b1, chte_pkg::ST_MISS, 8'd0});
    rows.push_back('{chte_pkg::CMD_CREATE,  64'd0, 1'b1, chte_pkg::ST_OK,   8'd255});
    rows.push_back('{chte_pkg::CMD_CREATE,  '1,    1'b1, chte_pkg::ST_OK,   8'd254});
    rows.push_back('{chte_pkg::CMD_CREATE,  '1,    1'b1, chte_pkg::ST_MISS, 8'd0});
    rows.push_back('{chte_pkg::CMD_FIND,    '1,    1'b1, chte_pkg::ST_OK,   8'd254});
    rows.push_back('{chte_pkg::CMD_FIND,    64'd0, 1'b1, chte_pkg::ST_OK,   8'd255});
    rows.push_back('{chte_pkg::CMD_CREATE,  ka,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_CREATE,  kb,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_CREATE,  kc,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_FIND,    kc,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_DESTROY, kb,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_FIND,    kc,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_DESTROY, ka,    1'b0, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_DESTROY, ka,    1'b1, chte_pkg::ST_MISS, 8'd0});
    rows.push_back('{chte_pkg::CMD_CREATE,  64'h8000_0000_0000_0001, 1'b0,
                     chte_pkg::ST_OK, 8'd0});
    rows.push_back('{chte_pkg::CMD_DESTROY, '1,    1'b1, chte_pkg::ST_OK,   8'd254});
    rows.push_back('{chte_pkg::CMD_CLEAR,   '1,    1'b1, chte_pkg::ST_OK,   8'd0});
    rows.push_back('{chte_pkg::CMD_FIND,    64'd0, 1'b1, chte_pkg::ST_MISS, 8'd0});
    rows.push_back('{chte_pkg::CMD_CREATE,  kc,    1'b1, chte_pkg::ST_OK,   8'd255});
    foreach (rows[i])
      send_command(rows[i].command, rows[i].key, rows[i].typed,
                   rows[i].status, rows[i].handle);

    // Fill the pool while the receiver holds off, then hit the full case.
    hold_sink = 1'b1;
    while (shd_free_n > 0) send_command(chte_pkg::CMD_CREATE, rand_key());
    send_command(chte_pkg::CMD_CREATE, rand_key(), 1, chte_pkg::ST_FULL, 8'd0);
    send_command(chte_pkg::CMD_FIND,
                 live_keys[$urandom_range(0, live_keys.size() - 1)]);
    // Sender pauses until every result is back.
    drop_valid();
    wait_drained();
    send_command(chte_pkg::CMD_CLEAR, rand_key(), 1, chte_pkg::ST_OK, 8'd0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 150) no_idle = 1'b1;
      roll = $urandom_range(0, 99);
      r2 = $urandom_range(0, 3);
      if (r2 == 0) k = bucket0_key();
      else k = rand_key();
      if (live_keys.size() > 0 && $urandom_range(0, 1))
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (roll < 40 && live_keys.size() < 200) send_command(chte_pkg::CMD_CREATE, k);
      else if (roll < 70) send_command(chte_pkg::CMD_FIND, k);
      else if (roll < 98) send_command(chte_pkg::CMD_DESTROY, k);
      else send_command(chte_pkg::CMD_CLEAR, k);
    end
    drop_valid();
    wait_drained();
    repeat (NE + 20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** chained_hash_table_engine: PASSED **");
    else
      $display("** chained_hash_table_engine: FAILED **");
    $finish;
  end

endmodule
